FILE: hw/rtl/bsfpwm_pkg.sv
`timescale 1ns / 1ps

package bsfpwm_pkg;

    // Speed range and configuration reset
    localparam logic [6:0] PCT_MAX         = 7'd100;
    localparam logic [6:0] STEP_RESET      = 7'd25;

    // floor(pct * 255 / 100) == (pct * DUTY_MULT) >> DUTY_SHIFT for pct in 0..100
    localparam logic [17:0] DUTY_MULT      = 18'd167117;
    localparam int          DUTY_SHIFT     = 16;

    // floor(x / 10) == (x * TENS_MULT) >> TENS_SHIFT for x in 0..99
    localparam logic [7:0]  TENS_MULT      = 8'd205;
    localparam int          TENS_SHIFT     = 11;

    // Display digit positions
    localparam logic [1:0] DIGIT_THOUSANDS = 2'd0;
    localparam logic [1:0] DIGIT_HUNDREDS  = 2'd1;
    localparam logic [1:0] DIGIT_TENS      = 2'd2;
    localparam logic [1:0] DIGIT_ONES      = 2'd3;

    // Seven-segment pattern for a decimal digit, bit0 is segment a, dot off
    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'd63;
            4'd1:    seg = 8'd6;
            4'd2:    seg = 8'd91;
            4'd3:    seg = 8'd79;
            4'd4:    seg = 8'd102;
            4'd5:    seg = 8'd109;
            4'd6:    seg = 8'd125;
            4'd7:    seg = 8'd7;
            4'd8:    seg = 8'd127;
            4'd9:    seg = 8'd111;
            default: seg = 8'd0;
        endcase
        return seg;
    endfunction

endpackage

FILE: hw/rtl/button_stepped_fan_pwm_with_display.sv
`timescale 1ns / 1ps

// A poll word sits in the input register from its accepting edge and moves into the result
// register once the result side is free; its four digit words then follow in turn on m_tready.
// The input register can take the next poll while the digits of the last one are emitted.
// Reset (aresetn low, synchronous): speed 0, both buttons disarmed, step 25, all words dropped.
module button_stepped_fan_pwm_with_display (
    input  logic        aclk,
    input  logic        aresetn,
    // poll words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] dec_button, [1] inc_button, [7:2] zero
    // digit words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] duty, [8] alarm, [15:9] percent, [23:16] segments
    output logic [1:0]  m_tuser,    // [1:0] digit_index
    output logic        m_tlast,
    // step size register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    import bsfpwm_pkg::*;

    logic [6:0]  step_reg;
    logic        in_valid_reg;
    logic        in_dec_reg;
    logic        in_inc_reg;
    logic        dec_armed_reg;
    logic        inc_armed_reg;
    logic [6:0]  speed_reg;
    logic [6:0]  speed_next;
    logic        alarm_reg;
    logic        alarm_next;
    logic        res_valid_reg;
    logic [1:0]  digit_reg;

    logic        advance;
    logic        last_beat;
    logic        dec_release;
    logic        inc_release;
    logic [6:0]  pct_after_dec;
    logic        dec_hit;
    logic [7:0]  inc_sum;
    logic        inc_hit;

    logic [24:0] duty_prod;
    logic [6:0]  below_hundred;
    logic [14:0] tens_prod;
    logic [3:0]  tens_digit;
    logic [6:0]  tens_times_ten;
    logic [6:0]  ones_full;
    logic [3:0]  hundreds_digit;
    logic [7:0]  seg;

    // Control flow
    assign last_beat = (digit_reg == DIGIT_ONES);
    assign advance   = in_valid_reg && (!res_valid_reg || (m_tready && last_beat));
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Button releases
    assign dec_release = !in_dec_reg && dec_armed_reg;
    assign inc_release = !in_inc_reg && inc_armed_reg;

    // Decrement first, clamp at zero
    always_comb begin
        dec_hit       = 1'b0;
        pct_after_dec = speed_reg;
        if (dec_release) begin
            if (step_reg > speed_reg) begin
                dec_hit       = 1'b1;
                pct_after_dec = 7'd0;
            end else begin
                pct_after_dec = speed_reg - step_reg;
            end
        end
    end

    // Then increment, clamp at full speed
    assign inc_sum = {1'b0, pct_after_dec} + {1'b0, step_reg};
    always_comb begin
        inc_hit    = 1'b0;
        speed_next = pct_after_dec;
        if (inc_release) begin
            if (inc_sum > {1'b0, PCT_MAX}) begin
                inc_hit    = 1'b1;
                speed_next = PCT_MAX;
            end else begin
                speed_next = inc_sum[6:0];
            end
        end
    end
    assign alarm_next = dec_hit || inc_hit;

    // Step register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            step_reg <= cfg_data;
        end
    end

    // Input register: hold the poll word until the result side frees up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_dec_reg <= s_tdata[0];
            in_inc_reg <= s_tdata[1];
        end
    end

    // Speed state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_armed_reg <= 1'b0;
            inc_armed_reg <= 1'b0;
            speed_reg     <= 7'd0;
            alarm_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            digit_reg     <= DIGIT_THOUSANDS;
        end else if (advance) begin
            dec_armed_reg <= in_dec_reg;
            inc_armed_reg <= in_inc_reg;
            speed_reg     <= speed_next;
            alarm_reg     <= alarm_next;
            res_valid_reg <= 1'b1;
            digit_reg     <= DIGIT_THOUSANDS;
        end else if (res_valid_reg && m_tready) begin
            // advance through the digits, drop the result after the ones digit
            digit_reg <= digit_reg + 2'd1;
            if (last_beat) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Duty and decimal digits of the held speed
    assign duty_prod      = 25'(speed_reg) * 25'(DUTY_MULT);
    assign hundreds_digit = (speed_reg >= PCT_MAX) ? 4'd1 : 4'd0;
    assign below_hundred  = (speed_reg >= PCT_MAX) ? (speed_reg - PCT_MAX) : speed_reg;
    assign tens_prod      = 15'(below_hundred) * 15'(TENS_MULT);
    assign tens_digit     = tens_prod[TENS_SHIFT +: 4];
    assign tens_times_ten = 7'({tens_digit, 3'b000}) + 7'({tens_digit, 1'b0});
    assign ones_full      = below_hundred - tens_times_ten;

    // Pick the segment pattern of the current digit
    always_comb begin
        unique case (digit_reg)
            DIGIT_THOUSANDS: seg = seg_of(4'd0);
            DIGIT_HUNDREDS:  seg = seg_of(hundreds_digit);
            DIGIT_TENS:      seg = seg_of(tens_digit);
            DIGIT_ONES:      seg = seg_of(ones_full[3:0]);
            default:         seg = seg_of(4'd0);
        endcase
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {seg, speed_reg, alarm_reg, duty_prod[DUTY_SHIFT +: 8]};
    assign m_tuser  = digit_reg;
    assign m_tlast  = last_beat;

endmodule
